@@ rtl/hdts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex digit trie store: shared definitions
// Widths, node numbering, result codes and the structures that pass between
// the walk sequencer, the child memory and the top level.
// ----------------------------------------------------------------------------
package hdts_pkg;

  // Node store geometry: one row of child pointers per node.
  localparam int unsigned NodeW    = 16;
  localparam int unsigned MaxNodes = 1 << NodeW;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned Alphabet = 1 << DigitW;
  localparam int unsigned IdW      = 12;
  localparam int unsigned StatusW  = 2;

  typedef logic [NodeW-1:0]  node_t;
  typedef logic [DigitW-1:0] digit_t;
  typedef logic [IdW-1:0]    id_t;

  // A full row holds the child pointers of one node, indexed by digit.
  typedef logic [Alphabet-1:0][NodeW-1:0] child_row_t;

  // The root is node 0 and can never be a child, so 0 also means "no child".
  localparam node_t RootNode = '0;
  localparam node_t NoChild  = '0;
  localparam node_t LastNode = NodeW'(MaxNodes - 1);

  // Command codes on the first digit of a key.
  localparam logic CmdInsert = 1'b0;
  localparam logic CmdLookup = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StInserted = 2'd0,
    StFound    = 2'd1,
    StNotFound = 2'd2,
    StFull     = 2'd3
  } status_e;

  // Request from the walk sequencer to the child memory.
  typedef struct packed {
    logic   rd_en;
    node_t  rd_row;
    logic   wr_en;
    logic   wr_clr;
    node_t  wr_row;
    digit_t wr_lane;
    node_t  wr_data;
  } child_req_t;

  // Result of one key, handed to the output register.
  typedef struct packed {
    status_e status;
    id_t     matched_id;
  } result_t;

endpackage

@@ rtl/hdts_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex digit trie store: channel interfaces
// The digit input channel and the result output channel, each with a
// valid/ready handshake and the payload fields.
// ----------------------------------------------------------------------------

// Digit channel: one hex digit of a key per transfer.
interface hdts_in_if
  import hdts_pkg::*;
  ();
  logic   valid;
  logic   ready;
  logic   cmd;
  digit_t digit;
  logic   last;
  id_t    entry_id;

  modport source (output valid, output cmd, output digit, output last, output entry_id,
                  input ready);
  modport sink   (input valid, input cmd, input digit, input last, input entry_id,
                  output ready);
endinterface

// Result channel: one transfer per completed key.
interface hdts_out_if
  import hdts_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  id_t                matched_id;

  modport source (output valid, output status, output matched_id, input ready);
  modport sink   (input valid, input status, input matched_id, output ready);
endinterface

@@ rtl/hdts_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex digit trie store: generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hdts_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned AddrW = 16
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [1 << AddrW];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/hdts_child_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex digit trie store: child pointer memory
// One row per node holding a child pointer for every digit. A write sets a
// single pointer through a lane enable, or clears a whole row; a read returns
// the whole row from a register in the next cycle.
// ----------------------------------------------------------------------------
module hdts_child_mem
  import hdts_pkg::*;
(
  input  logic       clk_i,
  input  child_req_t req_i,
  output child_row_t row_o
);

  child_row_t mem_q [MaxNodes];
  child_row_t row_q;

  // Write port: a clearing write zeroes the row, otherwise one lane is written.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      if (req_i.wr_clr) begin
        mem_q[req_i.wr_row] <= '0;
      end else begin
        mem_q[req_i.wr_row][req_i.wr_lane] <= req_i.wr_data;
      end
    end
  end

  // Registered read of a whole row.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      row_q <= mem_q[req_i.rd_row];
    end
  end

  assign row_o = row_q;

endmodule

@@ rtl/hdts_walk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex digit trie store: walk sequencer
// Clears the node store after reset, then takes one digit at a time, reads the
// child row of the current node, allocates or follows the child, and at the
// end of a key stores or fetches the entry id.
// ----------------------------------------------------------------------------
module hdts_walk
  import hdts_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  hdts_in_if.sink       in_i,
  output child_req_t    child_req_o,
  input  child_row_t    child_row_i,
  output logic          end_we_o,
  output node_t         end_waddr_o,
  output id_t           end_wdata_o,
  output logic          end_re_o,
  output node_t         end_raddr_o,
  input  id_t           end_rdata_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output result_t       res_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0] state_q, state_d;
  node_t      clr_q, clr_d;
  node_t      cursor_q, cursor_d;
  node_t      node_cnt_q, node_cnt_d;
  logic       key_open_q, key_open_d;
  logic       key_cmd_q, key_cmd_d;
  logic       miss_q, miss_d;
  logic       full_q, full_d;
  digit_t     digit_q, digit_d;
  logic       last_q, last_d;
  id_t        id_q, id_d;

  node_t      child;
  node_t      new_node;

  assign child    = child_row_i[digit_q];
  assign new_node = node_cnt_q + NodeW'(1);

  // Sequencer: clear pass, digit accept, row update, result hand-off.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cursor_d    = cursor_q;
    node_cnt_d  = node_cnt_q;
    key_open_d  = key_open_q;
    key_cmd_d   = key_cmd_q;
    miss_d      = miss_q;
    full_d      = full_q;
    digit_d     = digit_q;
    last_d      = last_q;
    id_d        = id_q;
    child_req_o = '0;
    end_we_o    = 1'b0;
    end_waddr_o = cursor_q;
    end_wdata_o = id_q;
    end_re_o    = 1'b0;
    end_raddr_o = cursor_q;
    res_valid_o = 1'b0;
    in_i.ready  = 1'b0;

    case (state_q)
      S_CLEAR: begin
        child_req_o.wr_en  = 1'b1;
        child_req_o.wr_clr = 1'b1;
        child_req_o.wr_row = clr_q;
        end_we_o           = 1'b1;
        end_waddr_o        = clr_q;
        end_wdata_o        = '0;
        clr_d              = clr_q + NodeW'(1);
        if (clr_q == LastNode) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        in_i.ready         = 1'b1;
        child_req_o.rd_row = key_open_q ? cursor_q : RootNode;
        if (in_i.valid) begin
          child_req_o.rd_en = 1'b1;
          digit_d           = in_i.digit;
          last_d            = in_i.last;
          id_d              = in_i.entry_id;
          // The first digit of a key opens it and fixes the command.
          if (!key_open_q) begin
            key_open_d = 1'b1;
            key_cmd_d  = in_i.cmd;
            miss_d     = 1'b0;
            full_d     = 1'b0;
            cursor_d   = RootNode;
          end
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        // Child row is available: allocate, follow or record a miss.
        if (key_cmd_q == CmdInsert) begin
          if (!full_q) begin
            if (child == NoChild) begin
              if (node_cnt_q == LastNode) begin
                full_d = 1'b1;
              end else begin
                node_cnt_d          = new_node;
                child_req_o.wr_en   = 1'b1;
                child_req_o.wr_row  = cursor_q;
                child_req_o.wr_lane = digit_q;
                child_req_o.wr_data = new_node;
                cursor_d            = new_node;
              end
            end else begin
              cursor_d = child;
            end
          end
        end else if (!miss_q) begin
          if (child == NoChild) begin
            miss_d = 1'b1;
          end else begin
            cursor_d = child;
          end
        end

        // At the end of the key, store the id or fetch it for the result.
        if (last_q) begin
          key_open_d  = 1'b0;
          end_waddr_o = cursor_d;
          end_raddr_o = cursor_d;
          end_we_o    = (key_cmd_q == CmdInsert) && !full_d;
          end_re_o    = (key_cmd_q == CmdLookup) && !miss_d;
          state_d     = S_RESP;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // Result fields of the key just ended.
  always_comb begin
    if (key_cmd_q == CmdInsert) begin
      res_o.status = full_q ? StFull : StInserted;
    end else begin
      res_o.status = miss_q ? StNotFound : StFound;
    end
    res_o.matched_id = ((key_cmd_q == CmdLookup) && !miss_q) ? end_rdata_i : '0;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      cursor_q   <= RootNode;
      node_cnt_q <= '0;
      key_open_q <= 1'b0;
      key_cmd_q  <= CmdInsert;
      miss_q     <= 1'b0;
      full_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      cursor_q   <= cursor_d;
      node_cnt_q <= node_cnt_d;
      key_open_q <= key_open_d;
      key_cmd_q  <= key_cmd_d;
      miss_q     <= miss_d;
      full_q     <= full_d;
    end
  end

  // Captured digit payload.
  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
    last_q  <= last_d;
    id_q    <= id_d;
  end

endmodule

@@ rtl/hex_digit_trie_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex digit trie store
// Radix-16 trie that inserts and looks up keys sent one hex digit at a time.
// ----------------------------------------------------------------------------
// After reset the block clears the node store (one node row per cycle) and
// takes no digit until that pass is done. Each digit first reads the child row
// of the current node from the child memory, whose read data is registered,
// and then allocates or follows the child and writes back. After the last
// digit of a key the entry id is stored or fetched, and the result passes
// through a response state into an output register, so the first digit of the
// next key is taken while that result still waits. A result is held back only
// when the previous one has not yet been taken.
// ----------------------------------------------------------------------------
module hex_digit_trie_store
  import hdts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  hdts_in_if.sink    in_i,
  hdts_out_if.source out_o
);

  child_req_t child_req;
  child_row_t child_row;
  logic       end_we;
  node_t      end_waddr;
  id_t        end_wdata;
  logic       end_re;
  node_t      end_raddr;
  id_t        end_rdata;
  logic       res_valid;
  logic       res_ready;
  result_t    res;

  logic       out_valid_q;
  result_t    out_res_q;

  hdts_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .child_req_o (child_req),
    .child_row_i (child_row),
    .end_we_o    (end_we),
    .end_waddr_o (end_waddr),
    .end_wdata_o (end_wdata),
    .end_re_o    (end_re),
    .end_raddr_o (end_raddr),
    .end_rdata_i (end_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  hdts_child_mem u_child_mem (
    .clk_i (clk_i),
    .req_i (child_req),
    .row_o (child_row)
  );

  hdts_ram #(
    .Width (IdW),
    .AddrW (NodeW)
  ) u_end_mem (
    .clk_i   (clk_i),
    .we_i    (end_we),
    .waddr_i (end_waddr),
    .wdata_i (end_wdata),
    .re_i    (end_re),
    .raddr_i (end_raddr),
    .rdata_o (end_rdata)
  );

  // The output register takes a new result once the previous one is transferred.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_res_q.status;
  assign out_o.matched_id = out_res_q.matched_id;

endmodule

@@ rtl/hdts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex digit trie store: port checker
// Watches the ports of the top level for handshake and result consistency.
// ----------------------------------------------------------------------------
module hdts_checker
  import hdts_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [StatusW-1:0] out_status_i,
  input id_t                out_matched_id_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // A stalled result keeps its valid and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_matched_id_i))
    else $error("Stalled result changed before transfer.");

  // Each digit passes through the row update before the next is taken, so no transfer follows another directly.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("Digit taken in the cycle after a digit transfer.");

  // Only a found key carries a non-zero id.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != StFound) |-> out_matched_id_i == '0)
    else $error("Non-zero id on a result that is not found.");

  // A result never appears in the cycle right after a digit transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_xfer))
    else $error("Result appeared too soon after a digit transfer.");

endmodule

bind hex_digit_trie_store hdts_checker u_hdts_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_status_i     (out_o.status),
  .out_matched_id_i (out_o.matched_id)
);

@@ tb/hex_digit_trie_store_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex digit trie store testbench
// Feeds keys one hex digit per transfer. A shadow trie predicts the status
// and id of every completed key, and each result transfer is checked against
// the oldest prediction. Short directed keys come first, then random keys
// built around a pool of stored keys, then closing keys on a stored key and
// on a fresh one. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module hex_digit_trie_store_test;
  import hdts_pkg::*;

  localparam int MaxKeyLen   = 256;
  localparam int RandomItems = 1700;
  localparam int HoldCycles  = 500;
  localparam int HoldAfter   = 60;

  typedef struct {
    int     len;
    digit_t d[MaxKeyLen];
  } hex_key_t;

  // Shadow trie: follows every accepted digit and queues the result that a
  // completed key should give.
  class trie_shadow;
    node_t       child_rows[int unsigned];
    id_t         end_ids[node_t];
    int unsigned node_count;
    node_t       cursor;
    logic        key_open;
    logic        key_cmd;
    logic        miss;
    logic        full;
    result_t     awaited[$];
    int          mismatches;

    function new();
      node_count = 0;
      cursor     = RootNode;
      key_open   = 1'b0;
      key_cmd    = CmdInsert;
      miss       = 1'b0;
      full       = 1'b0;
      mismatches = 0;
    endfunction

    // Notes one accepted digit and queues a result when it ends a key.
    function void take_digit(logic cmd, digit_t digit, logic last, id_t entry_id);
      int unsigned slot;
      node_t       child;
      result_t     res;
      if (!key_open) begin
        key_open = 1'b1;
        key_cmd  = cmd;
        cursor   = RootNode;
        miss     = 1'b0;
        full     = 1'b0;
      end
      slot  = int'(cursor) * Alphabet + int'(digit);
      child = child_rows.exists(slot) ? child_rows[slot] : NoChild;
      if (key_cmd == CmdInsert) begin
        if (!full) begin
          // A missing child takes the next node number unless the store is used up.
          if (child == NoChild) begin
            if (node_count >= MaxNodes - 1) begin
              full = 1'b1;
            end else begin
              node_count++;
              child = node_t'(node_count);
              child_rows[slot] = child;
            end
          end
          if (!full) cursor = child;
        end
      end else if (!miss) begin
        if (child == NoChild) miss = 1'b1;
        else cursor = child;
      end
      if (last) begin
        key_open       = 1'b0;
        res.matched_id = '0;
        if (key_cmd == CmdInsert) begin
          if (full) begin
            res.status = StFull;
          end else begin
            end_ids[cursor] = entry_id;
            res.status = StInserted;
          end
        end else if (miss) begin
          res.status = StNotFound;
        end else begin
          res.status     = StFound;
          res.matched_id = end_ids.exists(cursor) ? end_ids[cursor] : '0;
        end
        awaited = {awaited, res};
      end
    endfunction

    // Compares one result transfer with the oldest prediction.
    function void check_result(status_e status, id_t matched_id);
      result_t exp;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: status %s id %03h", $realtime,
                   status.name(), matched_id);
        return;
      end
      exp = awaited.pop_front();
      if (status != exp.status || matched_id != exp.matched_id) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result mismatch: expected %s id %03h, got %s id %03h",
                   $realtime, exp.status.name(), exp.matched_id, status.name(),
                   matched_id);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  hdts_in_if  in_if ();
  hdts_out_if out_if ();

  hex_digit_trie_store dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  trie_shadow shadow;
  hex_key_t   key_pool[$];
  int         results_taken = 0;
  int         burst_left;
  bit         sender_steady;

  // Clock: 8 ns period.
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Generous time limit for the whole run.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Watch both channels at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        shadow.take_digit(in_if.cmd, in_if.digit, in_if.last, in_if.entry_id);
      if (out_if.valid && out_if.ready) begin
        shadow.check_result(status_e'(out_if.status), out_if.matched_id);
        results_taken++;
      end
    end
  end

  // Result side: stall patterns drawn at random from four modes, and one long
  // hold-off that lets the block fill up and stop taking digits.
  initial begin
    int  mode;
    int  cycle;
    bit  held;
    out_if.ready = 1'b0;
    mode  = 0;
    cycle = 0;
    held  = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && results_taken >= HoldAfter) begin
        held = 1'b1;
        repeat (HoldCycles) begin
          @(negedge clk_i);
          out_if.ready <= 1'b0;
        end
      end else begin
        @(negedge clk_i);
        cycle++;
        if (cycle % 256 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= (cycle % 3 == 0);
          default: out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offers one digit and waits for its transfer. Digits come in bursts with
  // gaps between them unless the sender is in a steady stretch.
  task automatic send_digit(input logic cmd, input digit_t digit, input logic last,
                            input id_t entry_id);
    int gap;
    if (burst_left == 0) begin
      gap = 0;
      if (!sender_steady && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        in_if.cmd   <= 1'($urandom_range(0, 1));
        in_if.digit <= digit_t'($urandom_range(0, 15));
        in_if.last  <= 1'($urandom_range(0, 1));
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    in_if.valid    <= 1'b1;
    in_if.cmd      <= cmd;
    in_if.digit    <= digit;
    in_if.last     <= last;
    in_if.entry_id <= entry_id;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Sends a whole key. Only the first digit carries the real command and only
  // the last one the real id; the others carry noise in those fields.
  task automatic send_key(input logic cmd, input hex_key_t key, input id_t entry_id);
    for (int i = 0; i < key.len; i++) begin
      send_digit((i == 0) ? cmd : logic'($urandom_range(0, 1)), key.d[i],
                 i == key.len - 1,
                 (i == key.len - 1) ? entry_id : id_t'($urandom_range(0, 4095)));
    end
  endtask

  function automatic hex_key_t make_key(input int len);
    hex_key_t k;
    k.len = len;
    for (int i = 0; i < MaxKeyLen; i++)
      k.d[i] = (i < len) ? digit_t'($urandom_range(0, 15)) : '0;
    return k;
  endfunction

  function automatic hex_key_t fixed_key(input int len, input digit_t a, input digit_t b,
                                         input digit_t c);
    hex_key_t k;
    k = make_key(len);
    k.d[0] = a;
    k.d[1] = b;
    k.d[2] = c;
    return k;
  endfunction

  // Mostly short keys, some up to a 32-digit hash.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 16);
    return 32;
  endfunction

  initial begin
    hex_key_t k;
    int       sent;
    int       pick;
    int       pos;
    shadow        = new();
    burst_left    = 0;
    sender_steady = 1'b0;
    rst_ni        = 1'b0;
    in_if.valid    = 1'b0;
    in_if.cmd      = CmdInsert;
    in_if.digit    = '0;
    in_if.last     = 1'b0;
    in_if.entry_id = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed keys: a miss on the empty trie, insert and look up, a prefix,
    // a reinsert, a miss that holds to the end of the key, and single digits.
    send_key(CmdLookup, fixed_key(1, 4'h0, 4'h0, 4'h0), 12'h000);
    send_key(CmdInsert, fixed_key(3, 4'hF, 4'h0, 4'hA), 12'hFFF);
    send_key(CmdLookup, fixed_key(3, 4'hF, 4'h0, 4'hA), 12'h000);
    send_key(CmdLookup, fixed_key(2, 4'hF, 4'h0, 4'h0), 12'hABC);
    send_key(CmdInsert, fixed_key(3, 4'hF, 4'h0, 4'hA), 12'h001);
    send_key(CmdLookup, fixed_key(3, 4'hF, 4'h0, 4'hA), 12'h000);
    send_key(CmdLookup, fixed_key(3, 4'hF, 4'h5, 4'h0), 12'h000);
    send_key(CmdInsert, fixed_key(1, 4'h0, 4'h0, 4'h0), 12'h000);
    send_key(CmdLookup, fixed_key(1, 4'h0, 4'h0, 4'h0), 12'h000);
    key_pool = {key_pool, fixed_key(3, 4'hF, 4'h0, 4'hA)};
    key_pool = {key_pool, fixed_key(1, 4'h0, 4'h0, 4'h0)};

    // Random keys around the pool of stored keys.
    sent = 0;
    while (sent < RandomItems) begin
      if ($urandom_range(0, 39) == 0) sender_steady = !sender_steady;
      pick = $urandom_range(0, 9);
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (pick <= 2) begin
        k = make_key(pick_len());
        send_key(CmdInsert, k, id_t'($urandom_range(0, 4095)));
        if (key_pool.size() < 200) key_pool = {key_pool, k};
      end else if (pick == 3) begin
        send_key(CmdInsert, k, id_t'($urandom_range(0, 4095)));
      end else if (pick <= 6) begin
        send_key(CmdLookup, k, id_t'($urandom_range(0, 4095)));
      end else if (pick == 7) begin
        k.len = $urandom_range(1, k.len);
        send_key(CmdLookup, k, id_t'($urandom_range(0, 4095)));
      end else if (pick == 8) begin
        pos = $urandom_range(0, k.len - 1);
        k.d[pos] = k.d[pos] + digit_t'($urandom_range(1, 15));
        send_key(CmdLookup, k, id_t'($urandom_range(0, 4095)));
      end else begin
        k = make_key(pick_len());
        send_key(CmdLookup, k, id_t'($urandom_range(0, 4095)));
      end
      sent += k.len;
    end

    // Closing keys: a stored key inserted again and looked up, and a fresh
    // hash-length key inserted and looked up.
    sender_steady = 1'b1;
    send_key(CmdInsert, key_pool[0], 12'h5A5);
    send_key(CmdLookup, key_pool[0], 12'h000);
    k = make_key(32);
    send_key(CmdInsert, k, 12'hFFF);
    send_key(CmdLookup, k, 12'h000);
    @(negedge clk_i);
    in_if.valid <= 1'b0;

    // Drain the outstanding results, then let the block settle.
    while (shadow.awaited.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.awaited.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
